[hw/rtl/clipped_bresenham_line_writer_unit_assert.svh]
// Assertion macros for the clipped Bresenham line writer.
`ifndef CLIPPED_BRESENHAM_LINE_WRITER_UNIT_ASSERT_SVH
`define CLIPPED_BRESENHAM_LINE_WRITER_UNIT_ASSERT_SVH

// same-cycle implication
`define CBLW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBLW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cblw_pkg.sv]
// Shared constants and types for the clipped Bresenham line writer.
`default_nettype none

package cblw_pkg;

	localparam int IN_COORD_W = 16;
	localparam int COLOR_W    = 32;
	localparam int DIM_W      = 15;
	localparam int BYTES_W    = 32;
	localparam int FMT_W      = 2;
	localparam int CFG_IDX_W  = 3;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	localparam logic [FMT_W-1:0] FMT_RGB = 2'd0;
	localparam logic [FMT_W-1:0] FMT_BGR = 2'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FB_BASE,
		REG_FB_BYTES,
		REG_PIXEL_FORMAT,
		REG_SCREEN_WIDTH,
		REG_SCREEN_HEIGHT,
		REG_ROW_STRIDE
	} cfg_reg_t;

	typedef struct packed {
		logic             usable;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic [DIM_W-1:0] stride;
	} fb_geom_t;

endpackage

`default_nettype wire

[hw/rtl/cblw_req_if.sv]
// Request channel: line start or pixel step words.
`default_nettype none

interface cblw_req_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   req_type;
	logic signed [cblw_pkg::IN_COORD_W-1:0] x_start;
	logic signed [cblw_pkg::IN_COORD_W-1:0] y_start;
	logic signed [cblw_pkg::IN_COORD_W-1:0] x_end;
	logic signed [cblw_pkg::IN_COORD_W-1:0] y_end;
	logic [cblw_pkg::COLOR_W-1:0]           line_color_in;

	modport source (output valid, req_type, x_start, y_start, x_end, y_end, line_color_in,
		input ready);
	modport sink (input valid, req_type, x_start, y_start, x_end, y_end, line_color_in,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/cblw_pix_if.sv]
// Pixel write channel.
`default_nettype none

interface cblw_pix_if #(
	parameter int ADDR_BITS = 48
);
	logic                         valid;
	logic                         ready;
	logic                         write_enable;
	logic [ADDR_BITS-1:0]         pixel_address;
	logic [cblw_pkg::COLOR_W-1:0] pixel_value;
	logic                         last;

	modport source (output valid, write_enable, pixel_address, pixel_value, last,
		input ready);
	modport sink (input valid, write_enable, pixel_address, pixel_value, last,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/clipped_bresenham_line_writer_unit.sv]
// Top level of the clipped Bresenham line writer.
// Takes one request word per cycle while req.ready is high. A start word loads the endpoints
// and color and gives no pixel; each step word while a line is active gives one pixel write,
// which enters the stage-one register, is clipped and row multiplied into the stage-two
// register, then address added into the output register. The line stepper's error and
// position update sets the rate of one pixel per cycle while req.ready is high; req.ready
// drops only while the three-stage pixel pipeline is full and the output word is not being
// taken. The user must write framebuffer settings through the cfg port only while no pixel
// word is in flight; the block does not enforce it. A change applies from the next step word.
`default_nettype none

`include "clipped_bresenham_line_writer_unit_assert.svh"

module clipped_bresenham_line_writer_unit #(
	parameter int COORD_BITS = 16,
	parameter int ADDR_BITS  = 48
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [cblw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ADDR_BITS-1:0]           cfg_data,
	cblw_req_if.sink                            req,
	cblw_pix_if.source                          pix
);

	logic [ADDR_BITS-1:0]          fb_base_q;
	logic [cblw_pkg::BYTES_W-1:0]  fb_bytes_q;
	logic [cblw_pkg::FMT_W-1:0]    fmt_q;
	logic [cblw_pkg::DIM_W-1:0]    width_q, height_q, stride_q;

	logic [2*cblw_pkg::DIM_W-1:0]  area;
	logic [cblw_pkg::BYTES_W-1:0]  need_bytes;
	logic                          fb_ok;
	cblw_pkg::fb_geom_t            geom;

	logic                          acc, pipe_ready;
	logic                          st_valid, st_last;
	logic signed [COORD_BITS-1:0]  st_x, st_y;
	logic [cblw_pkg::COLOR_W-1:0]  st_color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_base_q  <= '0;
			fb_bytes_q <= '0;
			fmt_q      <= '0;
			width_q    <= '0;
			height_q   <= '0;
			stride_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				cblw_pkg::REG_FB_BASE:       fb_base_q  <= cfg_data;
				cblw_pkg::REG_FB_BYTES:      fb_bytes_q <= cfg_data[cblw_pkg::BYTES_W-1:0];
				cblw_pkg::REG_PIXEL_FORMAT:  fmt_q      <= cfg_data[cblw_pkg::FMT_W-1:0];
				cblw_pkg::REG_SCREEN_WIDTH:  width_q    <= cfg_data[cblw_pkg::DIM_W-1:0];
				cblw_pkg::REG_SCREEN_HEIGHT: height_q   <= cfg_data[cblw_pkg::DIM_W-1:0];
				cblw_pkg::REG_ROW_STRIDE:    stride_q   <= cfg_data[cblw_pkg::DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		area       = (2*cblw_pkg::DIM_W)'(stride_q) * (2*cblw_pkg::DIM_W)'(height_q);
		need_bytes = cblw_pkg::BYTES_W'({area, 2'b00});
		fb_ok      = (fb_base_q != '0) &&
			((fmt_q == cblw_pkg::FMT_RGB) || (fmt_q == cblw_pkg::FMT_BGR)) &&
			(stride_q >= width_q) && (need_bytes <= fb_bytes_q);
	end

	assign geom.usable = fb_ok;
	assign geom.width  = width_q;
	assign geom.height = height_q;
	assign geom.stride = stride_q;

	assign req.ready = pipe_ready;
	assign acc       = req.valid && pipe_ready;

	cblw_stepper #(
		.COORD_BITS(COORD_BITS)
	) u_stepper (
		.clk           (clk),
		.arst_n        (arst_n),
		.acc           (acc),
		.req_type      (req.req_type),
		.x_start       (req.x_start),
		.y_start       (req.y_start),
		.x_end         (req.x_end),
		.y_end         (req.y_end),
		.line_color_in (req.line_color_in),
		.pix_valid     (st_valid),
		.pix_x         (st_x),
		.pix_y         (st_y),
		.pix_last      (st_last),
		.pix_color     (st_color)
	);

	cblw_addr_pipe #(
		.COORD_BITS(COORD_BITS),
		.ADDR_BITS (ADDR_BITS)
	) u_addr_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (st_valid),
		.in_ready (pipe_ready),
		.in_x     (st_x),
		.in_y     (st_y),
		.in_last  (st_last),
		.in_color (st_color),
		.geom     (geom),
		.fb_base  (fb_base_q),
		.pix      (pix)
	);

	// back-pressure only comes from a stalled output word
	`CBLW_ASSERT_IMPL(a_ready_low_only_on_stall, clk, arst_n, !req.ready,
		pix.valid && !pix.ready, "request ready low without an output stall")
	// disabled writes carry a zero address
	`CBLW_ASSERT_IMPL(a_disabled_addr_zero, clk, arst_n, pix.valid && !pix.write_enable,
		pix.pixel_address == '0, "disabled pixel write with nonzero address")
	// a start word never yields a pixel word entering the pipe
	`CBLW_ASSERT_IMPL(a_start_no_pixel, clk, arst_n,
		acc && (req.req_type == cblw_pkg::REQ_START), !st_valid,
		"start word produced a pixel")

endmodule

`default_nettype wire

[hw/rtl/cblw_stepper.sv]
// Bresenham line state: loads endpoints on start, advances one point per step until the end point.
`default_nettype none

module cblw_stepper #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   acc,
	input  wire logic                                   req_type,
	input  wire logic signed [cblw_pkg::IN_COORD_W-1:0] x_start,
	input  wire logic signed [cblw_pkg::IN_COORD_W-1:0] y_start,
	input  wire logic signed [cblw_pkg::IN_COORD_W-1:0] x_end,
	input  wire logic signed [cblw_pkg::IN_COORD_W-1:0] y_end,
	input  wire logic [cblw_pkg::COLOR_W-1:0]           line_color_in,
	output logic                                        pix_valid,
	output logic signed [COORD_BITS-1:0]                pix_x,
	output logic signed [COORD_BITS-1:0]                pix_y,
	output logic                                        pix_last,
	output logic [cblw_pkg::COLOR_W-1:0]                pix_color
);

	localparam int DW  = COORD_BITS + 2;
	localparam int EW  = COORD_BITS + 3;
	localparam int E2W = COORD_BITS + 4;

	logic                          active_q;
	logic signed [COORD_BITS-1:0]  cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic                          dir_x_neg_q, dir_y_neg_q;
	logic signed [DW-1:0]          abs_dx_q, neg_abs_dy_q;
	logic signed [EW-1:0]          err_q;
	logic [cblw_pkg::COLOR_W-1:0]  color_q;

	logic signed [COORD_BITS-1:0]  x0, y0, x1, y1;
	logic signed [DW-1:0]          ddx, ddy, adx0, ndy0;
	logic signed [EW-1:0]          err0, err_nx, add_x, add_y;
	logic signed [E2W-1:0]         e2;
	logic                          step_x, step_y, at_goal;
	logic                          do_start, do_step;

	assign x0 = COORD_BITS'(x_start);
	assign y0 = COORD_BITS'(y_start);
	assign x1 = COORD_BITS'(x_end);
	assign y1 = COORD_BITS'(y_end);

	always_comb begin
		ddx  = DW'(x1) - DW'(x0);
		ddy  = DW'(y1) - DW'(y0);
		adx0 = (ddx < 0) ? -ddx : ddx;
		ndy0 = (ddy < 0) ? ddy : -ddy;
		err0 = EW'(adx0) + EW'(ndy0);
	end

	always_comb begin
		at_goal = (cur_x_q == goal_x_q) && (cur_y_q == goal_y_q);
		e2      = E2W'(err_q) <<< 1;
		step_x  = e2 >= E2W'(neg_abs_dy_q);
		step_y  = e2 <= E2W'(abs_dx_q);
		add_x   = step_x ? EW'(neg_abs_dy_q) : '0;
		add_y   = step_y ? EW'(abs_dx_q) : '0;
		err_nx  = err_q + add_x + add_y;
	end

	assign do_start = acc && (req_type == cblw_pkg::REQ_START);
	assign do_step  = acc && (req_type == cblw_pkg::REQ_STEP) && active_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			cur_x_q      <= '0;
			cur_y_q      <= '0;
			goal_x_q     <= '0;
			goal_y_q     <= '0;
			dir_x_neg_q  <= 1'b0;
			dir_y_neg_q  <= 1'b0;
			abs_dx_q     <= '0;
			neg_abs_dy_q <= '0;
			err_q        <= '0;
			color_q      <= '0;
		end else if (do_start) begin
			active_q     <= 1'b1;
			cur_x_q      <= x0;
			cur_y_q      <= y0;
			goal_x_q     <= x1;
			goal_y_q     <= y1;
			dir_x_neg_q  <= !(x0 < x1);
			dir_y_neg_q  <= !(y0 < y1);
			abs_dx_q     <= adx0;
			neg_abs_dy_q <= ndy0;
			err_q        <= err0;
			color_q      <= line_color_in;
		end else if (do_step) begin
			if (at_goal) begin
				active_q <= 1'b0;
			end else begin
				err_q <= err_nx;
				if (step_x) begin
					cur_x_q <= dir_x_neg_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
				end
				if (step_y) begin
					cur_y_q <= dir_y_neg_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
				end
			end
		end
	end

	assign pix_valid = do_step;
	assign pix_x     = cur_x_q;
	assign pix_y     = cur_y_q;
	assign pix_last  = at_goal;
	assign pix_color = color_q;

endmodule

`default_nettype wire

[hw/rtl/cblw_addr_pipe.sv]
// Pixel pipeline: clip test, row multiply, address add, output register.
`default_nettype none

module cblw_addr_pipe #(
	parameter int COORD_BITS = 16,
	parameter int ADDR_BITS  = 48
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [COORD_BITS-1:0]    in_x,
	input  wire logic signed [COORD_BITS-1:0]    in_y,
	input  wire logic                            in_last,
	input  wire logic [cblw_pkg::COLOR_W-1:0]    in_color,
	input  wire cblw_pkg::fb_geom_t              geom,
	input  wire logic [ADDR_BITS-1:0]            fb_base,
	cblw_pix_if.source                           pix
);

	localparam int CW     = (COORD_BITS > cblw_pkg::DIM_W) ? COORD_BITS : cblw_pkg::DIM_W;
	localparam int PROD_W = COORD_BITS + cblw_pkg::DIM_W;
	localparam int SUM_W  = (ADDR_BITS > PROD_W + 3) ? ADDR_BITS : PROD_W + 3;

	logic                          v_s1, last_s1;
	logic signed [COORD_BITS-1:0]  x_s1, y_s1;
	logic [cblw_pkg::COLOR_W-1:0]  color_s1;

	logic                          v_s2, en_s2, last_s2;
	logic [COORD_BITS-1:0]         x_s2;
	logic [PROD_W-1:0]             prod_s2;
	logic [cblw_pkg::COLOR_W-1:0]  color_s2;

	logic adv_s1, adv_s2, adv_out;
	logic on_scr, en;
	logic [CW-1:0] xu, yu;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0] offs, addr_sum;

	assign adv_out  = !pix.valid || pix.ready;
	assign adv_s2   = !v_s2 || adv_out;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_comb begin
		xu     = CW'(unsigned'(x_s1));
		yu     = CW'(unsigned'(y_s1));
		on_scr = !x_s1[COORD_BITS-1] && !y_s1[COORD_BITS-1] &&
			(xu < CW'(geom.width)) && (yu < CW'(geom.height));
		en     = on_scr && geom.usable;
		prod   = PROD_W'(unsigned'(y_s1)) * PROD_W'(geom.stride);
	end

	always_comb begin
		offs     = SUM_W'(prod_s2) + SUM_W'(x_s2);
		addr_sum = SUM_W'(fb_base) + (offs << 2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			pix.valid <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= in_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
			if (adv_out) begin
				pix.valid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			x_s1     <= in_x;
			y_s1     <= in_y;
			last_s1  <= in_last;
			color_s1 <= in_color;
		end
		if (adv_s2 && v_s1) begin
			en_s2    <= en;
			x_s2     <= unsigned'(x_s1);
			prod_s2  <= prod;
			last_s2  <= last_s1;
			color_s2 <= color_s1;
		end
		if (adv_out && v_s2) begin
			pix.write_enable  <= en_s2;
			pix.pixel_address <= en_s2 ? ADDR_BITS'(addr_sum) : '0;
			pix.pixel_value   <= color_s2;
			pix.last          <= last_s2;
		end
	end

endmodule

`default_nettype wire

[verif/cblw_pixel_checker.sv]
// Pixel checker: watches request, pixel and register ports against its own line walker.
`timescale 1ns / 100ps

module cblw_pixel_checker #(
	parameter int ADDR_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [cblw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_BITS-1:0]           cfg_data,
	cblw_req_if                            req,
	cblw_pix_if                            pix,
	output int                             errors,
	output int                             pending
);

	localparam longint unsigned PIX_BYTES = 4;

	typedef struct packed {
		logic                         write_enable;
		logic [ADDR_BITS-1:0]         pixel_address;
		logic [cblw_pkg::COLOR_W-1:0] pixel_value;
		logic                         last;
	} pix_word_t;

	pix_word_t pix_expected_q[$];

	// register mirror
	logic [ADDR_BITS-1:0]           fb_base;
	logic [cblw_pkg::BYTES_W-1:0]   fb_bytes;
	logic [cblw_pkg::FMT_W-1:0]     pix_fmt;
	logic [cblw_pkg::DIM_W-1:0]     scr_width;
	logic [cblw_pkg::DIM_W-1:0]     scr_height;
	logic [cblw_pkg::DIM_W-1:0]     row_stride;

	// line walker state
	logic                                   line_armed;
	logic signed [cblw_pkg::IN_COORD_W-1:0] pos_x, pos_y, end_x, end_y;
	logic                                   step_x_neg, step_y_neg;
	int                                     span_x, neg_span_y, bres_err;
	logic [cblw_pkg::COLOR_W-1:0]           color;

	function automatic logic fb_writable();
		return fb_base != '0 &&
			(pix_fmt == cblw_pkg::FMT_RGB || pix_fmt == cblw_pkg::FMT_BGR) &&
			row_stride >= scr_width &&
			64'(row_stride) * 64'(scr_height) * PIX_BYTES <= 64'(fb_bytes);
	endfunction

	task automatic flag_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		errors++;
		$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
	endtask

	task automatic load_line();
		logic signed [cblw_pkg::IN_COORD_W-1:0] x0, y0, x1, y1;
		int dy;
		x0 = req.x_start;
		y0 = req.y_start;
		x1 = req.x_end;
		y1 = req.y_end;
		pos_x = x0;
		pos_y = y0;
		end_x = x1;
		end_y = y1;
		step_x_neg = !(x0 < x1);
		step_y_neg = !(y0 < y1);
		span_x = int'(x1) - int'(x0);
		if (span_x < 0)
			span_x = -span_x;
		dy = int'(y1) - int'(y0);
		neg_span_y = (dy < 0) ? dy : -dy;
		bres_err = span_x + neg_span_y;
		color = req.line_color_in;
		line_armed = 1'b1;
	endtask

	task automatic emit_pixel();
		int cx, cy, e2;
		logic on_screen, hit_end;
		longint unsigned offs, full;
		pix_word_t w;
		cx = int'(pos_x);
		cy = int'(pos_y);
		on_screen = cx >= 0 && cy >= 0 && cx < int'(scr_width) && cy < int'(scr_height);
		hit_end = (pos_x == end_x) && (pos_y == end_y);
		w.write_enable = on_screen && fb_writable();
		w.pixel_address = '0;
		w.pixel_value = color;
		w.last = hit_end;
		if (w.write_enable) begin
			offs = 64'(cy) * 64'(row_stride) + 64'(cx);
			full = 64'(fb_base) + PIX_BYTES * offs;
			w.pixel_address = full[ADDR_BITS-1:0];
		end
		pix_expected_q.push_back(w);
		if (hit_end) begin
			line_armed = 1'b0;
		end else begin
			e2 = 2 * bres_err;
			if (e2 >= neg_span_y) begin
				bres_err += neg_span_y;
				pos_x = step_x_neg ? pos_x - 16'sd1 : pos_x + 16'sd1;
			end
			if (e2 <= span_x) begin
				bres_err += span_x;
				pos_y = step_y_neg ? pos_y - 16'sd1 : pos_y + 16'sd1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pix_word_t want;
		if (!arst_n) begin
			fb_base = '0;
			fb_bytes = '0;
			pix_fmt = '0;
			scr_width = '0;
			scr_height = '0;
			row_stride = '0;
			line_armed = 1'b0;
			pos_x = '0;
			pos_y = '0;
			end_x = '0;
			end_y = '0;
			step_x_neg = 1'b0;
			step_y_neg = 1'b0;
			span_x = 0;
			neg_span_y = 0;
			bres_err = 0;
			color = '0;
			pix_expected_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					cblw_pkg::REG_FB_BASE:       fb_base = cfg_data;
					cblw_pkg::REG_FB_BYTES:      fb_bytes = cfg_data[cblw_pkg::BYTES_W-1:0];
					cblw_pkg::REG_PIXEL_FORMAT:  pix_fmt = cfg_data[cblw_pkg::FMT_W-1:0];
					cblw_pkg::REG_SCREEN_WIDTH:  scr_width = cfg_data[cblw_pkg::DIM_W-1:0];
					cblw_pkg::REG_SCREEN_HEIGHT: scr_height = cfg_data[cblw_pkg::DIM_W-1:0];
					cblw_pkg::REG_ROW_STRIDE:    row_stride = cfg_data[cblw_pkg::DIM_W-1:0];
					default: ;
				endcase
			end
			if (pix.valid && pix.ready) begin
				if (pix_expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected pixel word, expected none, got address %h",
						$time, pix.pixel_address);
				end else begin
					want = pix_expected_q.pop_front();
					if (pix.write_enable !== want.write_enable)
						flag_field("write_enable", want.write_enable, pix.write_enable);
					if (pix.pixel_address !== want.pixel_address)
						flag_field("pixel_address", want.pixel_address, pix.pixel_address);
					if (pix.pixel_value !== want.pixel_value)
						flag_field("pixel_value", want.pixel_value, pix.pixel_value);
					if (pix.last !== want.last)
						flag_field("last", want.last, pix.last);
				end
			end
			if (req.valid && req.ready) begin
				if (req.req_type == cblw_pkg::REQ_START)
					load_line();
				else if (line_armed)
					emit_pixel();
			end
			pending = pix_expected_q.size();
		end
	end

endmodule

[verif/tb_clipped_bresenham_line_writer_unit.sv]
// Testbench top: bursty line and step words, register phases, and the verdict.
`timescale 1ns / 100ps

module tb_clipped_bresenham_line_writer_unit;

	localparam int ADDR_BITS       = 48;
	localparam int SETTLE_CYCLES   = 8;
	localparam int DRAIN_LIMIT     = 50000;
	localparam int LONG_HOLD       = 240;
	localparam int ITEMS_PER_PHASE = 64;
	localparam int NUM_PHASES      = 11;
	localparam int RUN_LIMIT_NS    = 2000000;

	localparam logic [cblw_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [cblw_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [cblw_pkg::FMT_W-1:0]     FMT_ODD_A    = 2'd2;
	localparam logic [cblw_pkg::FMT_W-1:0]     FMT_ODD_B    = 2'd3;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we;
	logic [cblw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_BITS-1:0]           cfg_data;
	int                             err_count;
	int                             pend_count;

	int burst_left = 0;
	bit no_gaps = 1'b0;
	int hold_asks = 0;
	int cur_w = 0;
	int cur_h = 0;

	cblw_req_if req_ch();
	cblw_pix_if #(.ADDR_BITS(ADDR_BITS)) pix_ch();

	clipped_bresenham_line_writer_unit #(
		.COORD_BITS(16),
		.ADDR_BITS(ADDR_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.pix(pix_ch)
	);

	cblw_pixel_checker #(.ADDR_BITS(ADDR_BITS)) pix_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req_ch),
		.pix(pix_ch),
		.errors(err_count),
		.pending(pend_count)
	);

	always #2 clk = ~clk;

	initial begin
		#RUN_LIMIT_NS;
		$display("[FAIL] regression broken");
		$finish;
	end

	// pixel sink: random ready pattern, plus a long hold when asked
	initial begin : pix_sink
		int seg_left, mode, hold_left, hold_seen;
		seg_left = 0;
		mode = 0;
		hold_left = 0;
		hold_seen = 0;
		pix_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = LONG_HOLD;
			end
			if (seg_left == 0) begin
				mode = $urandom_range(0, 3);
				seg_left = $urandom_range(4, 60);
			end
			seg_left--;
			if (hold_left > 0) begin
				hold_left--;
				pix_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: pix_ch.ready <= 1'b1;
					1: pix_ch.ready <= ($urandom_range(0, 1) == 1);
					2: pix_ch.ready <= ($urandom_range(0, 9) != 0);
					default: pix_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	task automatic send_word(input logic kind, input logic [15:0] xs, ys, xe, ye,
			input logic [31:0] col);
		int gap;
		if (!no_gaps && burst_left <= 0) begin
			gap = $urandom_range(1, 12);
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 10);
		end
		burst_left--;
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.x_start <= xs;
		req_ch.y_start <= ys;
		req_ch.x_end <= xe;
		req_ch.y_end <= ye;
		req_ch.line_color_in <= col;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic start_line(input logic signed [15:0] x0, y0, x1, y1,
			input logic [31:0] col);
		send_word(cblw_pkg::REQ_START, x0, y0, x1, y1, col);
	endtask

	// endpoint fields are don't-care on a step, so fill them with noise
	task automatic step_word();
		send_word(cblw_pkg::REQ_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), $urandom);
	endtask

	task automatic step_n(input int n);
		repeat (n) step_word();
	endtask

	task automatic settle();
		int guard;
		guard = 0;
		req_ch.valid <= 1'b0;
		// let the checker count a word taken at the edge just passed
		@(posedge clk);
		while (pend_count != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [47:0] with_junk(input logic [47:0] v, input int bits);
		logic [47:0] keep, junk;
		keep = (48'd1 << bits) - 48'd1;
		junk = 48'({$urandom, $urandom});
		return ($urandom_range(0, 1) == 1) ? (v | (junk & ~keep)) : v;
	endfunction

	task automatic cfg_put(input logic [cblw_pkg::CFG_IDX_W-1:0] idx,
			input logic [47:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic cfg_apply(input logic [47:0] base, input logic [31:0] bytes,
			input logic [1:0] fmt, input logic [14:0] w, h, stride);
		settle();
		if ($urandom_range(0, 1) == 1)
			cfg_put(REG_SPARE_LO, 48'({$urandom, $urandom}));
		cfg_put(cblw_pkg::REG_FB_BASE, base);
		cfg_put(cblw_pkg::REG_FB_BYTES, with_junk(48'(bytes), cblw_pkg::BYTES_W));
		cfg_put(cblw_pkg::REG_PIXEL_FORMAT, with_junk(48'(fmt), cblw_pkg::FMT_W));
		cfg_put(cblw_pkg::REG_SCREEN_WIDTH, with_junk(48'(w), cblw_pkg::DIM_W));
		cfg_put(cblw_pkg::REG_SCREEN_HEIGHT, with_junk(48'(h), cblw_pkg::DIM_W));
		cfg_put(cblw_pkg::REG_ROW_STRIDE, with_junk(48'(stride), cblw_pkg::DIM_W));
		if ($urandom_range(0, 1) == 1)
			cfg_put(REG_SPARE_HI, 48'({$urandom, $urandom}));
		cfg_we <= 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		cur_w = int'(w);
		cur_h = int'(h);
	endtask

	function automatic logic signed [15:0] near_coord(input int lim);
		case ($urandom_range(0, 2))
			0: return 16'($urandom_range(0, 40)) - 16'd8;
			1: return 16'(lim) + 16'($urandom_range(0, 24)) - 16'd12;
			default: return 16'($urandom_range(0, (lim > 0) ? lim - 1 : 0));
		endcase
	endfunction

	task automatic random_sequence(inout int count);
		int kind, ddx, ddy, len, n;
		logic signed [15:0] x0, y0, x1, y1;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			// stray step, may land with no line armed
			step_word();
			return;
		end
		if (kind < 22) begin
			x0 = 16'($urandom);
			y0 = 16'($urandom);
			x1 = 16'($urandom);
			y1 = 16'($urandom);
		end else begin
			x0 = near_coord(cur_w);
			y0 = near_coord(cur_h);
			x1 = x0 + 16'($urandom_range(0, 40)) - 16'd20;
			y1 = y0 + 16'($urandom_range(0, 40)) - 16'd20;
		end
		start_line(x0, y0, x1, y1, $urandom);
		count++;
		ddx = int'(x1) - int'(x0);
		ddy = int'(y1) - int'(y0);
		if (ddx < 0)
			ddx = -ddx;
		if (ddy < 0)
			ddy = -ddy;
		len = ((ddx > ddy) ? ddx : ddy) + 1;
		if (kind < 80 && len <= 64)
			n = len;
		else if (kind < 90 && len <= 64)
			n = len + $urandom_range(1, 3);
		else
			n = $urandom_range(0, (len < 30) ? len : 30);
		for (int i = 0; i < n; i++) begin
			step_word();
			if (i < len)
				count++;
		end
	endtask

	initial begin : stimulus
		int sent;
		cfg_we <= 1'b0;
		cfg_index <= cblw_pkg::REG_FB_BASE;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= cblw_pkg::REQ_STEP;
		req_ch.x_start <= '0;
		req_ch.y_start <= '0;
		req_ch.x_end <= '0;
		req_ch.y_end <= '0;
		req_ch.line_color_in <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: step with no line, then a line with writes disabled
		step_word();
		start_line(16'sd2, 16'sd2, 16'sd3, 16'sd3, 32'hA5A5_5A5A);
		step_word();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: cfg_apply(48'h0000_8000_0000, 32'hFFFF_FFFF, cblw_pkg::FMT_RGB,
					15'd40, 15'd30, 15'd48);
				1: cfg_apply(48'hFFFF_FFFF_FFC0, 32'h0010_0000, cblw_pkg::FMT_BGR,
					15'd64, 15'd64, 15'd64);
				2: cfg_apply(48'h0000_0000_0001, 32'hFFFF_FFFF, cblw_pkg::FMT_RGB,
					15'd16384, 15'd16384, 15'd16384);
				3: cfg_apply(48'({$urandom, $urandom}) | 48'd1, 32'hFFFF_FFFF,
					cblw_pkg::FMT_BGR, 15'd32767, 15'd32767, 15'd32767);
				4: cfg_apply(48'h0000_0000_1000, 32'hFFFF_FFFF, FMT_ODD_A,
					15'd40, 15'd30, 15'd40);
				5: cfg_apply(48'h0000_0000_1000, 32'hFFFF_FFFF, FMT_ODD_B,
					15'd40, 15'd30, 15'd40);
				6: cfg_apply(48'h0000_0000_1000, 32'hFFFF_FFFF, cblw_pkg::FMT_RGB,
					15'd50, 15'd20, 15'd49);
				7: cfg_apply(48'h0000_0002_0000, 32'd1000, cblw_pkg::FMT_RGB,
					15'd20, 15'd10, 15'd25);
				8: cfg_apply(48'h0000_0002_0000, 32'd999, cblw_pkg::FMT_BGR,
					15'd20, 15'd10, 15'd25);
				9: cfg_apply(48'h0, 32'h0, cblw_pkg::FMT_RGB, 15'd0, 15'd0, 15'd0);
				default: cfg_apply(48'({$urandom, $urandom}), $urandom, 2'($urandom),
					15'($urandom_range(0, 80)), 15'($urandom_range(0, 80)),
					15'($urandom_range(0, 96)));
			endcase

			if (ph == 0) begin
				// equal endpoints, then a trailing step that finds no line
				start_line(16'sd3, 16'sd4, 16'sd3, 16'sd4, 32'h0000_00FF);
				step_n(2);
				// starts off screen and walks in
				start_line(-16'sd2, -16'sd1, 16'sd2, 16'sd1, 32'h1234_5678);
				step_n(5);
				// steep, both directions negative, starts at the far corner
				start_line(16'sd39, 16'sd29, 16'sd38, 16'sd26, 32'h8000_0001);
				step_n(4);
				// extreme endpoints, dropped by a new start
				start_line(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF);
				step_word();
				start_line(16'sd1, 16'sd1, 16'sd1, 16'sd2, 32'h0000_0000);
				step_n(2);
				// settings change while a line is armed
				start_line(16'sd0, 16'sd0, 16'sd3, 16'sd0, 32'hC0FF_EE00);
				step_n(2);
				cfg_apply(48'h0000_8000_0000, 32'hFFFF_FFFF, cblw_pkg::FMT_RGB,
					15'd1, 15'd30, 15'd48);
				step_n(2);
				cfg_apply(48'h0000_8000_0000, 32'hFFFF_FFFF, cblw_pkg::FMT_RGB,
					15'd40, 15'd30, 15'd48);

				// long sink hold while words keep coming, then drain fully
				hold_asks++;
				no_gaps = 1'b1;
				start_line(16'sd0, 16'sd0, 16'sd39, 16'sd12, $urandom);
				step_n(40);
				no_gaps = 1'b0;
				settle();
			end

			sent = 0;
			while (sent < ITEMS_PER_PHASE)
				random_sequence(sent);
		end

		settle();
		if (err_count == 0 && pend_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
